[design/mdr_pkg.sv]
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared types and constants for the duty regulator: item structs, config
// struct, action codes and register map.
// ----------------------------------------------------------------------------
package mdr_pkg;

  // one measurement set
  typedef struct packed {
    logic [9:0]  out_current;
    logic [9:0]  out_voltage;
    logic [9:0]  in_voltage;
    logic [15:0] in_power;
  } mdr_in_t;

  // one result
  typedef struct packed {
    logic [11:0] duty;
    logic [2:0]  action;
  } mdr_out_t;

  typedef enum logic [2:0] {
    ACT_HOLD      = 3'd0,
    ACT_UP_ONE    = 3'd1,
    ACT_DOWN_ONE  = 3'd2,
    ACT_UP_STEP   = 3'd3,
    ACT_DOWN_STEP = 3'd4
  } mdr_act_t;

  // configuration as stored (duty limits at their register width)
  typedef struct packed {
    logic        work_mode;
    logic [9:0]  current_limit;
    logic [9:0]  voltage_target;
    logic [11:0] duty_max;
    logic [11:0] duty_min;
    logic [9:0]  input_floor;
    logic [5:0]  mppt_step;
  } mdr_cfg_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_WORK_MODE      = 3'd0;
  localparam logic [2:0] REG_CURRENT_LIMIT  = 3'd1;
  localparam logic [2:0] REG_VOLTAGE_TARGET = 3'd2;
  localparam logic [2:0] REG_DUTY_MAX       = 3'd3;
  localparam logic [2:0] REG_DUTY_MIN       = 3'd4;
  localparam logic [2:0] REG_INPUT_FLOOR    = 3'd5;
  localparam logic [2:0] REG_MPPT_STEP      = 3'd6;

  localparam logic        RST_WORK_MODE      = 1'b1;
  localparam logic [9:0]  RST_CURRENT_LIMIT  = 10'd100;
  localparam logic [9:0]  RST_VOLTAGE_TARGET = 10'd120;
  localparam logic [11:0] RST_DUTY_MAX       = 12'd4095;
  localparam logic [11:0] RST_DUTY_MIN       = 12'd0;
  localparam logic [9:0]  RST_INPUT_FLOOR    = 10'd80;
  localparam logic [5:0]  RST_MPPT_STEP      = 6'd4;

endpackage

[design/mdr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mdr_cfg_regs
// APB register file for the regulator settings, with read back.
// ----------------------------------------------------------------------------
module mdr_cfg_regs #(
  parameter int DUTY_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mdr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mdr_pkg::mdr_cfg_t          cfg
);
  import mdr_pkg::*;

  mdr_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [DUTY_BITS+11:0] max_wide;
  logic [DUTY_BITS+11:0] min_wide;
  logic [DUTY_BITS+11:0] wr_wide;
  logic [11:0] wr_duty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // duty limits are kept masked to the duty width
  assign wr_wide = {{DUTY_BITS{1'b0}}, pwdata[11:0]} &
                   {12'd0, {DUTY_BITS{1'b1}}};
  assign wr_duty = wr_wide[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_mode      <= RST_WORK_MODE;
      cfg_r.current_limit  <= RST_CURRENT_LIMIT;
      cfg_r.voltage_target <= RST_VOLTAGE_TARGET;
      cfg_r.duty_max       <= max_wide[11:0];
      cfg_r.duty_min       <= RST_DUTY_MIN;
      cfg_r.input_floor    <= RST_INPUT_FLOOR;
      cfg_r.mppt_step      <= RST_MPPT_STEP;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WORK_MODE:      cfg_r.work_mode      <= pwdata[0];
        REG_CURRENT_LIMIT:  cfg_r.current_limit  <= pwdata[9:0];
        REG_VOLTAGE_TARGET: cfg_r.voltage_target <= pwdata[9:0];
        REG_DUTY_MAX:       cfg_r.duty_max       <= wr_duty;
        REG_DUTY_MIN:       cfg_r.duty_min       <= wr_duty;
        REG_INPUT_FLOOR:    cfg_r.input_floor    <= pwdata[9:0];
        REG_MPPT_STEP:      cfg_r.mppt_step      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // reset value of duty_max masked the same way
  assign max_wide = {{DUTY_BITS{1'b0}}, RST_DUTY_MAX} &
                    {12'd0, {DUTY_BITS{1'b1}}};
  assign min_wide = '0;

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      REG_WORK_MODE:      prdata = {31'd0, cfg_r.work_mode};
      REG_CURRENT_LIMIT:  prdata = {22'd0, cfg_r.current_limit};
      REG_VOLTAGE_TARGET: prdata = {22'd0, cfg_r.voltage_target};
      REG_DUTY_MAX:       prdata = {20'd0, cfg_r.duty_max};
      REG_DUTY_MIN:       prdata = {20'd0, cfg_r.duty_min | min_wide[11:0]};
      REG_INPUT_FLOOR:    prdata = {22'd0, cfg_r.input_floor};
      REG_MPPT_STEP:      prdata = {26'd0, cfg_r.mppt_step};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[design/mdr_step_logic.sv]
// ----------------------------------------------------------------------------
// mdr_step_logic
// Combinational decision for one measurement set: picks the action,
// applies it to the duty and clamps to max then min.
// ----------------------------------------------------------------------------
module mdr_step_logic #(
  parameter int DUTY_BITS = 12
) (
  input  mdr_pkg::mdr_cfg_t  cfg,
  input  mdr_pkg::mdr_in_t   item,
  input  logic [DUTY_BITS-1:0] duty_now,
  input  logic [9:0]         prev_in_voltage,
  input  logic [15:0]        prev_in_power,
  output mdr_pkg::mdr_out_t  res,
  output logic [DUTY_BITS-1:0] duty_nxt,
  output logic               upd_prev
);
  import mdr_pkg::*;

  localparam int SW = DUTY_BITS + 2;

  mdr_act_t act;
  logic over_lim, under_tgt, mppt_fault;
  logic p_up, p_dn, v_up, v_dn;
  logic signed [SW-1:0] d_base, d_step, d_sum, d_max, d_min, d_clip;
  logic [DUTY_BITS+11:0] max_wide, min_wide, duty_wide;

  assign over_lim   = (item.out_current > cfg.current_limit) ||
                      (item.out_voltage > cfg.voltage_target);
  assign under_tgt  = item.out_voltage < cfg.voltage_target;
  assign mppt_fault = (item.in_voltage < cfg.input_floor) || over_lim;

  assign p_up = item.in_power > prev_in_power;
  assign p_dn = item.in_power < prev_in_power;
  assign v_up = item.in_voltage > prev_in_voltage;
  assign v_dn = item.in_voltage < prev_in_voltage;

  always_comb begin
    act = ACT_HOLD;
    if (!cfg.work_mode) begin
      if (over_lim)       act = ACT_DOWN_ONE;
      else if (under_tgt) act = ACT_UP_ONE;
    end else if (mppt_fault) begin
      act = ACT_DOWN_ONE;
    end else if ((p_up && v_up) || (p_dn && v_dn)) begin
      act = ACT_DOWN_STEP;
    end else if ((p_up && v_dn) || (p_dn && v_up)) begin
      act = ACT_UP_STEP;
    end else if (under_tgt) begin
      act = ACT_UP_ONE;
    end
  end

  assign upd_prev = cfg.work_mode && !mppt_fault;

  // limits at the duty width (zero-extended or masked)
  assign max_wide = {{DUTY_BITS{1'b0}}, cfg.duty_max};
  assign min_wide = {{DUTY_BITS{1'b0}}, cfg.duty_min};

  assign d_base = signed'({2'b00, duty_now});
  assign d_step = signed'({{(SW-6){1'b0}}, cfg.mppt_step});
  assign d_max  = signed'({2'b00, max_wide[DUTY_BITS-1:0]});
  assign d_min  = signed'({2'b00, min_wide[DUTY_BITS-1:0]});

  always_comb begin
    case (act)
      ACT_UP_ONE:    d_sum = d_base + SW'(1);
      ACT_DOWN_ONE:  d_sum = d_base - SW'(1);
      ACT_UP_STEP:   d_sum = d_base + d_step;
      ACT_DOWN_STEP: d_sum = d_base - d_step;
      default:       d_sum = d_base;
    endcase
  end

  // min is applied last so it wins over max
  always_comb begin
    d_clip = d_sum;
    if (d_clip > d_max) d_clip = d_max;
    if (d_clip < d_min) d_clip = d_min;
  end

  assign duty_nxt  = d_clip[DUTY_BITS-1:0];
  assign duty_wide = {12'd0, duty_nxt};
  assign res.duty   = duty_wide[11:0];
  assign res.action = act;

endmodule

[design/mppt_duty_regulator_top.sv]
// ----------------------------------------------------------------------------
// mppt_duty_regulator_top
// Buck duty regulator with CC/CV and perturb-and-observe MPPT modes.
// ----------------------------------------------------------------------------
//  channel | ports                                  | payload
//  in      | in_valid, in_stall, in_data           | mdr_in_t measurement set
//  out     | out_valid, out_stall, out_data        | mdr_out_t duty and action
//  cfg     | psel penable pwrite paddr pwdata ...  | 7 registers at 4*i
//
//  one item per cycle sustained while out_stall is low (input register, then
//  decision and clamp into the result register); duty updates as an item
//  enters the result register, previous input values too in fault-free MPPT
//  mode; synchronous active-low reset clears control and state, loads settings'
//  reset values; a stalled result holds; input register still fills behind it
// ----------------------------------------------------------------------------
module mppt_duty_regulator_top #(
  parameter int DUTY_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mdr_pkg::mdr_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mdr_pkg::mdr_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mdr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mdr_pkg::*;

  mdr_cfg_t cfg;

  logic                 s1_valid_r;
  mdr_in_t              s1_data_r;
  logic                 out_valid_r;
  mdr_out_t             out_data_r;
  logic [DUTY_BITS-1:0] duty_now_r;
  logic [9:0]           prev_in_voltage_r;
  logic [15:0]          prev_in_power_r;

  mdr_out_t             res;
  logic [DUTY_BITS-1:0] duty_nxt;
  logic                 upd_prev;
  logic                 out_free, move, in_take;

  mdr_cfg_regs #(.DUTY_BITS(DUTY_BITS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdr_step_logic #(.DUTY_BITS(DUTY_BITS)) u_step (
    .cfg             (cfg),
    .item            (s1_data_r),
    .duty_now        (duty_now_r),
    .prev_in_voltage (prev_in_voltage_r),
    .prev_in_power   (prev_in_power_r),
    .res             (res),
    .duty_nxt        (duty_nxt),
    .upd_prev        (upd_prev)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign move     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      duty_now_r        <= '0;
      prev_in_voltage_r <= '0;
      prev_in_power_r   <= '0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (out_free)  out_valid_r <= s1_valid_r;
      if (move) begin
        duty_now_r <= duty_nxt;
        if (upd_prev) begin
          prev_in_voltage_r <= s1_data_r.in_voltage;
          prev_in_power_r   <= s1_data_r.in_power;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r  <= in_data;
    if (move)    out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/mdr_checker.sv]
// ----------------------------------------------------------------------------
// mdr_checker
// Port-level checks on the regulator's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module mdr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mdr_pkg::mdr_out_t out_data
);
  import mdr_pkg::*;

  // the input side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // a fresh result comes from a word taken into the input register, then moved into the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input word");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind mppt_duty_regulator_top mdr_checker u_mdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
